// ----- src/fwrl_pkg.sv -----
package fwrl_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int KEY_W    = 32;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 17;
    localparam int VERD_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        REG_LIMIT_ENABLE   = 2'd0,
        REG_MAX_REQUESTS   = 2'd1,
        REG_WINDOW_SECONDS = 2'd2
    } reg_idx_t;

    localparam logic [VERD_W-1:0] VERDICT_ALLOW = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_DENY  = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_FULL  = 2'd2;

    // Priority chain passed from cell to cell
    typedef struct packed {
        logic               hit;
        logic               free;
        logic [COUNT_W-1:0] count;
    } chain_t;

    typedef struct packed {
        logic check_en;
        logic update_en;
        logic limit_en;
        logic any_hit;
    } cell_ctrl_t;

endpackage

// ----- src/fwrl_cell.sv -----
module fwrl_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fwrl_pkg::cell_ctrl_t        ctrl,
    input  logic [fwrl_pkg::KEY_W-1:0]  req_key,
    input  logic [fwrl_pkg::TIME_W-1:0] req_now,
    input  logic [fwrl_pkg::CFG_W-1:0]  max_requests,
    input  logic [fwrl_pkg::CFG_W-1:0]  window_seconds,
    input  fwrl_pkg::chain_t            chain_in,
    output fwrl_pkg::chain_t            chain_out
);
    import fwrl_pkg::*;

    logic               valid_reg, valid_next;
    logic               match_reg, match_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [TIME_W-1:0]  age;
    logic               expired;
    logic [COUNT_W:0]   incr;
    logic [COUNT_W:0]   cap;
    logic [COUNT_W-1:0] new_count;
    logic               hit_sel;
    logic               free_sel;

    assign age      = req_now - start_reg;
    assign expired  = ctrl.limit_en && valid_reg &&
                      (age >= {{(TIME_W-CFG_W){1'b0}}, window_seconds});
    assign incr     = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign cap      = {{(COUNT_W+1-CFG_W){1'b0}}, max_requests} + {{COUNT_W{1'b0}}, 1'b1};
    assign new_count = (incr > cap) ? cap[COUNT_W-1:0] : incr[COUNT_W-1:0];

    assign hit_sel  = match_reg && !chain_in.hit;
    assign free_sel = !valid_reg && !chain_in.free;

    assign chain_out.hit   = chain_in.hit | match_reg;
    assign chain_out.free  = chain_in.free | !valid_reg;
    assign chain_out.count = chain_in.count | (hit_sel ? new_count : '0);

    always_comb begin
        valid_next = valid_reg;
        match_next = match_reg;
        key_next   = key_reg;
        start_next = start_reg;
        count_next = count_reg;
        if (ctrl.check_en) begin
            if (expired) begin
                valid_next = 1'b0;
            end
            match_next = valid_reg && !expired && (key_reg == req_key);
        end
        if (ctrl.update_en && ctrl.limit_en) begin
            if (hit_sel) begin
                count_next = new_count;
            end else if (free_sel && !ctrl.any_hit) begin
                valid_next = 1'b1;
                key_next   = req_key;
                start_next = req_now;
                count_next = {{(COUNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
        key_reg   <= key_next;
        start_reg <= start_next;
        count_reg <= count_next;
    end

endmodule

// ----- src/fixed_window_rate_limiter.sv -----
// Fixed-window rate limiter over a row of TABLE_ENTRIES table cells.
// Each request takes an expiry/match check pass, then an update pass through
// the cell row; a new request is accepted together with the update of the last
// one. A waiting result holds back only the update step.
// Reset (aresetn low, synchronous): all entries invalid, state, result valid and config registers cleared.
module fixed_window_rate_limiter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fwrl_pkg::KEY_W-1:0]     s_client_key,
    input  logic [fwrl_pkg::TIME_W-1:0]    s_now_seconds,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fwrl_pkg::VERD_W-1:0]    m_verdict,
    output logic [fwrl_pkg::COUNT_W-1:0]   m_request_count,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fwrl_pkg::ADDR_W-1:0]    paddr,
    input  logic [fwrl_pkg::DATA_W-1:0]    pwdata,
    output logic [fwrl_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import fwrl_pkg::*;

    state_t              state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                m_valid_reg, m_valid_next;
    logic [VERD_W-1:0]   m_verdict_reg, m_verdict_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                limit_enable_reg, limit_enable_next;
    logic [CFG_W-1:0]    max_requests_reg, max_requests_next;
    logic [CFG_W-1:0]    window_seconds_reg, window_seconds_next;

    logic                out_free;
    logic                check_en;
    logic                update_en;
    logic                cfg_write;
    reg_idx_t            cfg_idx;
    cell_ctrl_t          ctrl;
    chain_t              chain [0:TABLE_ENTRIES];

    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_LIMIT_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, limit_enable_reg};
            REG_MAX_REQUESTS:   prdata = {{(DATA_W-CFG_W){1'b0}}, max_requests_reg};
            REG_WINDOW_SECONDS: prdata = {{(DATA_W-CFG_W){1'b0}}, window_seconds_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        limit_enable_next   = limit_enable_reg;
        max_requests_next   = max_requests_reg;
        window_seconds_next = window_seconds_reg;
        if (cfg_write) begin
            case (cfg_idx)
                REG_LIMIT_ENABLE:   limit_enable_next   = pwdata[0];
                REG_MAX_REQUESTS:   max_requests_next   = pwdata[CFG_W-1:0];
                REG_WINDOW_SECONDS: window_seconds_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        check_en   = 1'b0;
        update_en  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                check_en   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    update_en  = 1'b1;
                    s_ready    = 1'b1;
                    state_next = s_valid ? ST_CHECK : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign key_next = (s_valid && s_ready) ? s_client_key : key_reg;
    assign now_next = (s_valid && s_ready) ? s_now_seconds : now_reg;

    assign ctrl.check_en  = check_en;
    assign ctrl.update_en = update_en;
    assign ctrl.limit_en  = limit_enable_reg;
    assign ctrl.any_hit   = chain[TABLE_ENTRIES].hit;

    assign chain[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        fwrl_cell u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .ctrl           (ctrl),
            .req_key        (key_reg),
            .req_now        (now_reg),
            .max_requests   (max_requests_reg),
            .window_seconds (window_seconds_reg),
            .chain_in       (chain[i]),
            .chain_out      (chain[i+1])
        );
    end

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_verdict_next = m_verdict_reg;
        m_count_next   = m_count_reg;
        if (update_en) begin
            m_valid_next = 1'b1;
            if (!limit_enable_reg) begin
                m_verdict_next = VERDICT_ALLOW;
                m_count_next   = '0;
            end else if (chain[TABLE_ENTRIES].hit) begin
                m_count_next   = chain[TABLE_ENTRIES].count;
                m_verdict_next = (chain[TABLE_ENTRIES].count >
                                  {{(COUNT_W-CFG_W){1'b0}}, max_requests_reg})
                                 ? VERDICT_DENY : VERDICT_ALLOW;
            end else if (chain[TABLE_ENTRIES].free) begin
                m_verdict_next = VERDICT_ALLOW;
                m_count_next   = {{(COUNT_W-1){1'b0}}, 1'b1};
            end else begin
                m_verdict_next = VERDICT_FULL;
                m_count_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            limit_enable_reg   <= 1'b0;
            max_requests_reg   <= '0;
            window_seconds_reg <= '0;
        end else begin
            state_reg          <= state_next;
            m_valid_reg        <= m_valid_next;
            limit_enable_reg   <= limit_enable_next;
            max_requests_reg   <= max_requests_next;
            window_seconds_reg <= window_seconds_next;
        end
        key_reg       <= key_next;
        now_reg       <= now_next;
        m_verdict_reg <= m_verdict_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_verdict       = m_verdict_reg;
    assign m_request_count = m_count_reg;

endmodule

// ----- src/fwrl_checker.sv -----
module fwrl_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [fwrl_pkg::VERD_W-1:0]  m_verdict,
    input logic [fwrl_pkg::COUNT_W-1:0] m_request_count
);
    import fwrl_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_request_count))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted during check pass");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_FULL) |-> m_request_count == '0)
        else $error("untracked request with nonzero count");

    a_deny_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_DENY) |-> m_request_count != '0)
        else $error("denied request with zero count");

endmodule

bind fixed_window_rate_limiter fwrl_checker u_fwrl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_verdict       (m_verdict),
    .m_request_count (m_request_count)
);

// ----- dv/rate_limit_checker.sv -----
`timescale 1ns / 1ps

module rate_limit_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [fwrl_pkg::KEY_W-1:0]   s_client_key,
    input  logic [fwrl_pkg::TIME_W-1:0]  s_now_seconds,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [fwrl_pkg::VERD_W-1:0]  m_verdict,
    input  logic [fwrl_pkg::COUNT_W-1:0] m_request_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fwrl_pkg::ADDR_W-1:0]  paddr,
    input  logic [fwrl_pkg::DATA_W-1:0]  pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending
);
    import fwrl_pkg::*;

    typedef struct {
        logic [VERD_W-1:0]  verdict;
        logic [COUNT_W-1:0] count;
    } decision_t;

    logic               lim_en;
    logic [CFG_W-1:0]   max_req;
    logic [CFG_W-1:0]   win_len;

    logic               tbl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]   tbl_key   [TABLE_ENTRIES];
    logic [TIME_W-1:0]  tbl_start [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl_count [TABLE_ENTRIES];

    decision_t decisions_due[$];
    decision_t want;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic decision_t rate_decision(input logic [KEY_W-1:0] key,
                                                input logic [TIME_W-1:0] now);
        decision_t          d;
        int                 hit;
        int                 free_idx;
        logic [TIME_W-1:0]  age;
        logic [COUNT_W-1:0] cap;
        logic [COUNT_W-1:0] next;
        d.verdict = VERDICT_ALLOW;
        d.count   = '0;
        hit       = -1;
        free_idx  = -1;
        if (lim_en) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                age = now - tbl_start[i];
                if (tbl_valid[i] && age >= TIME_W'(win_len))
                    tbl_valid[i] = 1'b0;
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_key[i] == key)
                        hit = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit >= 0) begin
                cap  = COUNT_W'(max_req) + COUNT_W'(1);
                next = tbl_count[hit] + COUNT_W'(1);
                if (next > cap)
                    next = cap;
                tbl_count[hit] = next;
                d.count   = next;
                d.verdict = (next > COUNT_W'(max_req)) ? VERDICT_DENY : VERDICT_ALLOW;
            end else if (free_idx >= 0) begin
                tbl_valid[free_idx] = 1'b1;
                tbl_key[free_idx]   = key;
                tbl_start[free_idx] = now;
                tbl_count[free_idx] = COUNT_W'(1);
                d.count = COUNT_W'(1);
            end else begin
                d.verdict = VERDICT_FULL;
            end
        end
        return d;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lim_en  = 1'b0;
            max_req = '0;
            win_len = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            decisions_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_LIMIT_ENABLE:   lim_en  = pwdata[0];
                    REG_MAX_REQUESTS:   max_req = pwdata[CFG_W-1:0];
                    REG_WINDOW_SECONDS: win_len = pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (decisions_due.size() == 0) begin
                    $error("result with no request waiting: verdict %0d, count %0d",
                           m_verdict, m_request_count);
                    fail_count++;
                end else begin
                    want = decisions_due.pop_front();
                    if (m_verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d",
                               want.verdict, m_verdict);
                        fail_count++;
                    end
                    if (m_request_count !== want.count) begin
                        $error("request_count: expected %0d, actual %0d",
                               want.count, m_request_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                decisions_due.push_back(rate_decision(s_client_key, s_now_seconds));
        end
        pending = decisions_due.size();
    end

endmodule

// ----- dv/tb_fixed_window_rate_limiter.sv -----
`timescale 1ns / 1ps

module tb_fixed_window_rate_limiter;
    import fwrl_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int POOL_MAX      = 24;
    localparam logic [KEY_W-1:0] KEY_A = 32'hC0A8_0001;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [KEY_W-1:0]   s_client_key = '0;
    logic [TIME_W-1:0]  s_now_seconds = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VERD_W-1:0]  m_verdict;
    logic [COUNT_W-1:0] m_request_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    logic [KEY_W-1:0]  key_pool [POOL_MAX];
    int                pool_size;
    logic [TIME_W-1:0] now_s;
    logic [CFG_W-1:0]  max_val;
    logic [CFG_W-1:0]  win_val;
    logic              en_val;

    fixed_window_rate_limiter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_client_key    (s_client_key),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_request_count (m_request_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    rate_limit_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_client_key    (s_client_key),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict       (m_verdict),
        .m_request_count (m_request_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
            default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
        endcase
    endtask

    // entered and left at a falling edge
    task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_client_key  = key;
        s_now_seconds = now;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        s_valid = 1'b0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        set_idling(0);

        // disabled after reset: everything passes
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hA5A5_5A5A, 32'h8000_0000);
        drain();

        // upper bits must be masked off
        write_reg(REG_MAX_REQUESTS, 32'h1234_0003);
        write_reg(REG_WINDOW_SECONDS, 32'hFFFF_0064);
        write_reg(REG_LIMIT_ENABLE, 32'hFFFF_FFFF);

        // count up past the limit, then hold at the cap
        repeat (5) send_request(KEY_A, 32'd1000);
        // fill the table, last one goes untracked
        for (int i = 1; i <= TABLE_ENTRIES; i++)
            send_request(KEY_A ^ (32'h0101_0000 * i), 32'd1001);
        drain();

        // lowered limit clamps an existing count
        write_reg(REG_MAX_REQUESTS, 32'd1);
        send_request(KEY_A, 32'd1050);
        drain();

        // zero window expires everything
        write_reg(REG_WINDOW_SECONDS, 32'd0);
        send_request(KEY_A, 32'd1050);
        send_request(KEY_A, 32'd1050);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_idling(p % 4);
            en_val = (p != 5);
            case (p)
                0: begin max_val = 16'd0;     win_val = 16'd5;     end
                1: begin max_val = 16'hFFFF;  win_val = 16'hFFFF;  end
                2: begin max_val = 16'd1;     win_val = 16'd0;     end
                3: begin max_val = 16'd2;     win_val = 16'd3;     end
                4: begin max_val = CFG_W'($urandom_range(0, 4));
                         win_val = CFG_W'($urandom_range(1, 20)); end
                5: begin max_val = 16'd7;     win_val = 16'd10;    end
                6: begin max_val = 16'd3;     win_val = 16'd2;     end
                default: begin max_val = CFG_W'($urandom_range(0, 10));
                               win_val = CFG_W'($urandom_range(0, 40)); end
            endcase
            write_reg(REG_MAX_REQUESTS, {16'($urandom_range(16'hFFFF)), max_val});
            write_reg(REG_WINDOW_SECONDS, {16'($urandom_range(16'hFFFF)), win_val});
            write_reg(REG_LIMIT_ENABLE, ($urandom & 32'hFFFF_FFFE) | en_val);

            now_s     = (p == 3) ? 32'hFFFF_FFF0 : $urandom;
            pool_size = $urandom_range(4, POOL_MAX);
            for (int j = 0; j < POOL_MAX; j++)
                key_pool[j] = $urandom;
            key_pool[0] = (p % 2) ? 32'h0000_0000 : 32'hFFFF_FFFF;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 3)
                    now_s = now_s + $urandom_range(0, 100);
                else
                    now_s = now_s + $urandom_range(0, 2);
                if ($urandom_range(99) < 5)
                    send_request($urandom, now_s);
                else
                    send_request(key_pool[$urandom_range(0, pool_size - 1)], now_s);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/fwrl_pkg.sv
src/fwrl_cell.sv
src/fixed_window_rate_limiter.sv
src/fwrl_checker.sv
dv/rate_limit_checker.sv
dv/tb_fixed_window_rate_limiter.sv
